// File: design/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TSC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TSC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tsc_pkg.sv
`default_nettype none

package tsc_pkg;

  // Widths of the configuration channel and the elapsed-time counter.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TIME_W     = 16;
  localparam int unsigned ELAPSED_W  = 17;

  // The elapsed-time counter saturates at its all-ones value.
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOGGLE_MODE     = 2'd0,
    REG_ON_TIME_MS      = 2'd1,
    REG_OFF_TIME_MS     = 2'd2,
    REG_INVERT_POLARITY = 2'd3
  } tsc_reg_t;

  // Current configuration as seen by the core.
  typedef struct packed {
    logic              toggle_mode;
    logic [TIME_W-1:0] on_time_ms;
    logic [TIME_W-1:0] off_time_ms;
    logic              invert_polarity;
  } tsc_cfg_t;

  // Fields of one input item.
  typedef struct packed {
    logic control_in;
    logic force_on_req;
    logic force_off_req;
  } tsc_in_t;

  // Fields of one result item.
  typedef struct packed {
    logic switch_state;
    logic pin_level;
    logic state_changed;
  } tsc_result_t;

endpackage

`default_nettype wire

// File: design/tsc_if.sv
`default_nettype none

// Input channel: one control sample per millisecond tick.
interface tsc_in_if;
  logic valid;
  logic ready;
  logic control_in;
  logic force_on_req;
  logic force_off_req;

  modport source (output valid, output control_in, output force_on_req,
                  output force_off_req, input ready);
  modport sink (input valid, input control_in, input force_on_req,
                input force_off_req, output ready);
endinterface

// Result channel: switch state after each tick.
interface tsc_out_if;
  logic valid;
  logic ready;
  logic switch_state;
  logic pin_level;
  logic state_changed;

  modport source (output valid, output switch_state, output pin_level,
                  output state_changed, input ready);
  modport sink (input valid, input switch_state, input pin_level,
                input state_changed, output ready);
endinterface

// Configuration write channel.
interface tsc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tsc_pkg::CFG_IDX_W-1:0]   index;
  logic [tsc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/timed_switch_controller_top.sv
// Channel   Dir  Handshake       Payload
// in_ch     in   valid / ready   control_in, force_on_req, force_off_req
// out_ch    out  valid / ready   switch_state, pin_level, state_changed
// cfg_ch    in   valid / ready   index (2 bits), data (16 bits)
//
// One item per clock unless stalled; its result is valid the next cycle.
// The state update and the result register form a single stage: the next
// item is taken while the previous result waits, as long as it is drained.
// Reset (rst, synchronous) zeroes the config and all state but result data.
// A stalled result blocks new items only while out_ch.ready stays low.
`default_nettype none

module timed_switch_controller_top (
  input  logic     clk,
  input  logic     rst,
  tsc_in_if.sink   in_ch,
  tsc_out_if.source out_ch,
  tsc_cfg_if.sink  cfg_ch
);
  import tsc_pkg::*;

  tsc_cfg_t    cfg_q;
  tsc_in_t     in_item;
  tsc_result_t result;
  logic        in_ready;
  logic        accept;

  assign in_item.control_in    = in_ch.control_in;
  assign in_item.force_on_req  = in_ch.force_on_req;
  assign in_item.force_off_req = in_ch.force_off_req;
  assign in_ch.ready           = in_ready;
  assign accept                = in_ch.valid && in_ready;

  // Configuration registers.
  tsc_cfg_regs u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .cfg_q  (cfg_q)
  );

  // Switch state and per-tick update.
  tsc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_item (in_item),
    .cfg_q   (cfg_q),
    .result  (result)
  );

  // Result register toward the output channel.
  tsc_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .result   (result),
    .in_ready (in_ready),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// File: design/tsc_cfg_regs.sv
`default_nettype none

module tsc_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  tsc_cfg_if.sink           cfg_ch,
  output tsc_pkg::tsc_cfg_t cfg_q
);
  import tsc_pkg::*;

  tsc_cfg_t regs;

  // Writes are always taken.
  assign cfg_ch.ready = 1'b1;
  assign cfg_q        = regs;

  // Register file, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_TOGGLE_MODE:     regs.toggle_mode     <= cfg_ch.data[0];
        REG_ON_TIME_MS:      regs.on_time_ms      <= cfg_ch.data[TIME_W-1:0];
        REG_OFF_TIME_MS:     regs.off_time_ms     <= cfg_ch.data[TIME_W-1:0];
        REG_INVERT_POLARITY: regs.invert_polarity <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/tsc_core.sv
`default_nettype none
`include "assert_macros.svh"

module tsc_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  tsc_pkg::tsc_in_t     in_item,
  input  tsc_pkg::tsc_cfg_t    cfg_q,
  output tsc_pkg::tsc_result_t result
);
  import tsc_pkg::*;

  logic                 output_on;
  logic                 previous_input;
  logic [ELAPSED_W-1:0] elapsed_ms;
  logic                 pending_on;
  logic                 pending_off;

  logic                 output_on_next;
  logic                 previous_input_next;
  logic [ELAPSED_W-1:0] elapsed_ms_next;
  logic                 pending_on_next;
  logic                 pending_off_next;

  logic                 pend_on_now;
  logic                 pend_off_now;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic                 rise;
  logic                 fall;
  logic                 timed_out;
  logic                 off_expired;
  logic                 forced;
  logic                 changed;

  // Requests of this tick merge into the pending bits, then time advances.
  always_comb begin
    pend_on_now  = pending_on | in_item.force_on_req;
    pend_off_now = pending_off | in_item.force_off_req;
    elapsed_inc  = (elapsed_ms == ELAPSED_MAX) ? elapsed_ms
                                               : elapsed_ms + ELAPSED_W'(1);
    rise         = in_item.control_in & ~previous_input;
    fall         = ~in_item.control_in & previous_input;
    timed_out    = (cfg_q.on_time_ms != '0) &&
                   (elapsed_inc > {1'b0, cfg_q.on_time_ms});
    off_expired  = elapsed_inc > {1'b0, cfg_q.off_time_ms};
  end

  // Output update: a pending force wins, otherwise the mode rule applies.
  always_comb begin
    output_on_next   = output_on;
    pending_on_next  = pend_on_now;
    pending_off_next = pend_off_now;
    forced           = 1'b0;
    if (!output_on) begin
      if (pend_on_now) begin
        pending_on_next = 1'b0;
        forced          = 1'b1;
        output_on_next  = 1'b1;
      end else if (cfg_q.toggle_mode || cfg_q.on_time_ms == '0) begin
        if (rise) output_on_next = 1'b1;
      end else begin
        if (rise || (in_item.control_in && off_expired)) output_on_next = 1'b1;
      end
    end else begin
      if (pend_off_now) begin
        pending_off_next = 1'b0;
        forced           = 1'b1;
        output_on_next   = 1'b0;
      end else if (cfg_q.toggle_mode) begin
        if (rise || timed_out) output_on_next = 1'b0;
      end else begin
        if (fall || timed_out) output_on_next = 1'b0;
      end
    end
    changed             = output_on_next != output_on;
    elapsed_ms_next     = changed ? '0 : elapsed_inc;
    previous_input_next = forced ? previous_input : in_item.control_in;
  end

  // Result of this tick, loaded into the output register by the top level.
  assign result.switch_state  = output_on_next;
  assign result.pin_level     = output_on_next ^ cfg_q.invert_polarity;
  assign result.state_changed = changed;

  // Switch state, advanced once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      output_on      <= 1'b0;
      previous_input <= 1'b0;
      elapsed_ms     <= '0;
      pending_on     <= 1'b0;
      pending_off    <= 1'b0;
    end else if (accept) begin
      output_on      <= output_on_next;
      previous_input <= previous_input_next;
      elapsed_ms     <= elapsed_ms_next;
      pending_on     <= pending_on_next;
      pending_off    <= pending_off_next;
    end
  end

  // A change of the output restarts the elapsed-time count.
  `TSC_ASSERT_NXT(a_change_clears_time, clk, rst, accept && changed, elapsed_ms == '0,
    "elapsed time not cleared on output change")
  // Without an item the switch state holds.
  `TSC_ASSERT_NXT(a_idle_holds, clk, rst, !accept, $stable(output_on) && $stable(elapsed_ms),
    "switch state moved without an item")
  // A pending force-on while off is consumed and turns the output on.
  `TSC_ASSERT_NXT(a_force_on, clk, rst, accept && !output_on && pending_on,
    output_on && !pending_on, "pending force-on not applied")
  // A pending force-off while on is consumed and turns the output off.
  `TSC_ASSERT_NXT(a_force_off, clk, rst, accept && output_on && pending_off,
    !output_on && !pending_off, "pending force-off not applied")

endmodule

`default_nettype wire

// File: design/tsc_out_reg.sv
`default_nettype none
`include "assert_macros.svh"

module tsc_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  tsc_pkg::tsc_result_t result,
  output logic                 in_ready,
  tsc_out_if.source            out_ch
);
  import tsc_pkg::*;

  logic        valid;
  tsc_result_t data;

  // A new item may enter when the register is empty or being drained.
  assign in_ready = !valid || out_ch.ready;

  // Valid flag of the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

  assign out_ch.valid         = valid;
  assign out_ch.switch_state  = data.switch_state;
  assign out_ch.pin_level     = data.pin_level;
  assign out_ch.state_changed = data.state_changed;

  // Every loaded item shows up as a result in the next cycle.
  `TSC_ASSERT_NXT(a_load_shows, clk, rst, load, valid, "loaded item not presented")
  // The register is never loaded while a result is stuck.
  `TSC_ASSERT_IMP(a_no_overwrite, clk, rst, valid && !out_ch.ready, !load,
    "result overwritten while stalled")

endmodule

`default_nettype wire

// File: bench/tsc_tb_pkg.sv
`timescale 1ns / 100ps

package tsc_tb_pkg;
  import tsc_pkg::*;

  // Tracks the expected switch behavior tick by tick and checks each result against it.
  class switch_tracker;
    // Local copy of the configuration registers.
    bit                  toggle_mode;
    bit [TIME_W-1:0]     on_limit;
    bit [TIME_W-1:0]     off_limit;
    bit                  invert;

    // Local copy of the switch state.
    bit                  is_on;
    bit                  last_ctl;
    bit                  hold_on;
    bit                  hold_off;
    bit [ELAPSED_W-1:0]  ticks;

    tsc_result_t         pending_results[$];
    int unsigned         errors;
    int unsigned         results_checked;

    // Mirror a configuration write; only the low bits of each register are kept.
    function void write_reg(tsc_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TOGGLE_MODE:     toggle_mode = data[0];
        REG_ON_TIME_MS:      on_limit = data[TIME_W-1:0];
        REG_OFF_TIME_MS:     off_limit = data[TIME_W-1:0];
        REG_INVERT_POLARITY: invert = data[0];
        default: ;
      endcase
    endfunction

    // Advance the switch by one accepted tick and queue the state it must report.
    function void take_tick(tsc_in_t item);
      bit rise;
      bit fall;
      bit nxt;
      bit forced;
      bit timed_out;
      tsc_result_t res;
      forced = 1'b0;

      // Requests are latched before anything else happens on this tick.
      if (item.force_on_req) hold_on = 1'b1;
      if (item.force_off_req) hold_off = 1'b1;

      // The elapsed counter saturates instead of wrapping.
      if (ticks != ELAPSED_MAX) ticks++;

      rise = item.control_in & ~last_ctl;
      fall = ~item.control_in & last_ctl;
      timed_out = (on_limit != 0) && (ticks > on_limit);
      nxt = is_on;

      if (!is_on) begin
        if (hold_on) begin
          hold_on = 1'b0;
          forced = 1'b1;
          nxt = 1'b1;
        end else if (toggle_mode || on_limit == 0) begin
          if (rise) nxt = 1'b1;
        end else if (rise || (item.control_in && ticks > off_limit)) begin
          // Repeat mode: a held input re-triggers after the off time.
          nxt = 1'b1;
        end
      end else begin
        if (hold_off) begin
          hold_off = 1'b0;
          forced = 1'b1;
          nxt = 1'b0;
        end else if (toggle_mode) begin
          if (rise || timed_out) nxt = 1'b0;
        end else if (fall || timed_out) begin
          nxt = 1'b0;
        end
      end

      res.state_changed = (nxt != is_on);
      if (res.state_changed) begin
        is_on = nxt;
        ticks = '0;
      end
      // A consumed force request leaves the edge detector untouched.
      if (!forced) last_ctl = item.control_in;

      res.switch_state = is_on;
      res.pin_level = is_on ^ invert;
      pending_results.push_back(res);
    endfunction

    function void flag(string what, logic want, logic got);
      if (want !== got) begin
        errors++;
        if (errors <= 10)
          $display("%0t: %s mismatch, expected %0b, got %0b", $realtime, what, want, got);
      end
    endfunction

    // Compare one accepted result with the oldest expected state.
    function void check_result(tsc_result_t got);
      tsc_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result %0b%0b%0b arrived with no tick outstanding", $realtime,
                   got.switch_state, got.pin_level, got.state_changed);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        flag("switch_state", want.switch_state, got.switch_state);
        flag("pin_level", want.pin_level, got.pin_level);
        flag("state_changed", want.state_changed, got.state_changed);
      end
    endfunction
  endclass

endpackage

// File: bench/tb_timed_switch_controller_top.sv
`timescale 1ns / 100ps

module tb_timed_switch_controller_top;
  import tsc_pkg::*;
  import tsc_tb_pkg::*;

  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned TICKS_PER_PHASE = 100;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned LONG_ON_LIMIT   = 100;
  localparam int unsigned FULL_ON_TICKS   = 105;

  // Directed tick codes {control_in, force_on_req, force_off_req}, first tick leftmost.
  localparam logic [35:0] FOLLOW_SEQ = {3'b000, 3'b100, 3'b100, 3'b000, 3'b001, 3'b000,
                                        3'b100, 3'b110, 3'b010, 3'b011, 3'b111, 3'b000};
  localparam logic [26:0] TOGGLE_SEQ = {3'b100, 3'b000, 3'b000, 3'b000, 3'b000, 3'b000,
                                        3'b100, 3'b000, 3'b100};
  localparam logic [23:0] REPEAT_SEQ = {3'b100, 3'b100, 3'b100, 3'b100, 3'b100, 3'b100,
                                        3'b100, 3'b100};

  logic clk;
  logic rst;

  tsc_in_if  in_ch ();
  tsc_out_if out_ch ();
  tsc_cfg_if cfg_ch ();

  switch_tracker tracker;
  bit            no_gaps;
  int unsigned   quiet_cycles;

  timed_switch_controller_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: end the run if no channel completes a handshake for too long.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d cycles without a handshake.", quiet_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Send one tick after a random gap; valid stays high for a following tick.
  task automatic send_tick(input tsc_in_t item);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.control_in = item.control_in;
    in_ch.force_on_req = item.force_on_req;
    in_ch.force_off_req = item.force_off_req;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.take_tick(item);
    @(negedge clk);
  endtask

  task automatic send_codes(input logic [59:0] codes, input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_tick(codes[3*(count-1-i) +: 3]);
  endtask

  task automatic write_reg(input tsc_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    tracker.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Write all four registers; called only while no tick is outstanding.
  task automatic configure(input logic [15:0] tog_d, input logic [15:0] on_d,
                           input logic [15:0] off_d, input logic [15:0] inv_d);
    write_reg(REG_TOGGLE_MODE, tog_d);
    write_reg(REG_ON_TIME_MS, on_d);
    write_reg(REG_OFF_TIME_MS, off_d);
    write_reg(REG_INVERT_POLARITY, inv_d);
    cfg_ch.valid = 1'b0;
  endtask

  // Stop sending and wait until every outstanding result has been checked.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Random timer value, biased toward short limits that expire within a phase.
  function automatic logic [15:0] pick_time();
    case ($urandom_range(0, 7))
      0: pick_time = 16'h0000;
      1: pick_time = 16'hFFFF;
      2: pick_time = 16'($urandom());
      default: pick_time = 16'($urandom_range(1, 24));
    endcase
  endfunction

  // Result side: random stall before each item, then check it when accepted.
  initial begin : result_sink
    tsc_result_t got;
    int unsigned stall;
    out_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.switch_state = out_ch.switch_state;
      got.pin_level = out_ch.pin_level;
      got.state_changed = out_ch.state_changed;
      tracker.check_result(got);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    tsc_in_t item;
    int unsigned run_len;
    int unsigned sent;
    int unsigned guard;
    int unsigned mode;
    int unsigned leftover;
    logic [15:0] tog_d;
    logic [15:0] on_d;
    logic [15:0] off_d;
    bit level;
    bit noisy;

    tracker = new();
    no_gaps = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.control_in = 1'b0;
    in_ch.force_on_req = 1'b0;
    in_ch.force_off_req = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_TOGGLE_MODE;
    cfg_ch.data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: edges and force requests in follow mode, including requests that
    // wait for the opposite state, then a toggle timeout and repeat re-triggering.
    configure(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_codes(FOLLOW_SEQ, 12);
    settle();
    configure(16'h0001, 16'd3, 16'd0, 16'h0001);
    send_codes(TOGGLE_SEQ, 9);
    settle();
    configure(16'h0000, 16'd2, 16'd1, 16'h0000);
    send_codes(REPEAT_SEQ, 8);

    // Long on time in toggle mode: turn the switch on cleanly, then wait for the timeout.
    settle();
    no_gaps = 1'b1;
    configure(16'hFFFF, 16'(LONG_ON_LIMIT), 16'h0000, 16'h0000);
    guard = 0;
    while (!(tracker.is_on && !tracker.hold_on && !tracker.hold_off) && guard < 8) begin
      item = '0;
      item.force_on_req = !tracker.is_on && !tracker.hold_on;
      item.force_off_req = tracker.is_on && tracker.hold_on && !tracker.hold_off;
      send_tick(item);
      guard++;
    end
    repeat (FULL_ON_TICKS) send_tick(3'b000);
    no_gaps = 1'b0;

    // Random phases: held input levels with occasional glitches and force requests.
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      no_gaps = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 2);
      tog_d = 16'($urandom());
      tog_d[0] = (mode == 0);
      on_d = (mode == 1) ? 16'h0000 : pick_time();
      if (mode == 2 && on_d == 0) on_d = 16'd1;
      off_d = pick_time();
      configure(tog_d, on_d, off_d, 16'($urandom()));
      sent = 0;
      while (sent < TICKS_PER_PHASE) begin
        level = 1'($urandom_range(0, 1));
        noisy = ($urandom_range(0, 7) == 0);
        run_len = $urandom_range(1, 30);
        repeat (run_len) begin
          item.control_in = noisy ? 1'($urandom_range(0, 1)) : level;
          item.force_on_req = ($urandom_range(0, 15) == 0);
          item.force_off_req = ($urandom_range(0, 15) == 0);
          send_tick(item);
          sent++;
        end
      end
    end

    settle();
    no_gaps = 1'b0;
    repeat (4) @(negedge clk);
    leftover = tracker.pending_results.size();
    if (leftover != 0)
      $display("%0d expected results never arrived.", leftover);

    $display("Checked %0d ticks across toggle, follow and repeat modes with force requests,",
             tracker.results_checked);
    $display("random stalls and a long toggle-mode on-time timeout; %0d mismatches.",
             tracker.errors);
    if (tracker.errors == 0 && leftover == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/tsc_pkg.sv
design/tsc_if.sv
design/tsc_cfg_regs.sv
design/tsc_core.sv
design/tsc_out_reg.sv
design/timed_switch_controller_top.sv
bench/tsc_tb_pkg.sv
bench/tb_timed_switch_controller_top.sv
